// File: rtl/core/ftp_pkg.sv
// shared types and constants for the flow tuple header parser
`default_nettype none

package ftp_pkg;

  // byte position within a frame, saturates at PosMax
  typedef logic [6:0] pos_t;

  localparam pos_t PosMax = 7'd78;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam pos_t EthTypeHiAt = 7'd12;
  localparam pos_t EthTypeLoAt = 7'd13;
  localparam pos_t EthHdrLen   = 7'd14;

  // ipv4 with a fixed 20-byte header
  localparam pos_t V4ProtoAt = 7'd23;
  localparam pos_t V4SrcAt   = 7'd26;
  localparam pos_t V4DstAt   = 7'd30;
  localparam pos_t V4L4Base  = 7'd34;

  // ipv6 with a fixed 40-byte header
  localparam pos_t V6ProtoAt = 7'd20;
  localparam pos_t V6SrcAt   = 7'd22;
  localparam pos_t V6DstAt   = 7'd38;
  localparam pos_t V6L4Base  = 7'd54;

  localparam pos_t SmallL4Len = 7'd8;
  localparam pos_t TcpHdrLen  = 7'd20;

  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [1:0] {
    L3_OTHER = 2'd0,
    L3_IPV4  = 2'd1,
    L3_IPV6  = 2'd2
  } l3_kind_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        pass;
    logic [1:0]  l3_kind;
    logic [7:0]  l4_kind;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] sport;
    logic [15:0] dport;
  } out_item_t;

  // occupancy of the verdict queue as seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

`default_nettype wire

// File: rtl/core/ftp_front.sv
// front part: tracks byte position, captures header fields, builds the verdict
`default_nettype none

module ftp_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ftp_pkg::in_item_t  in_item_i,
  input  wire logic               q_full_i,
  output logic                    push_o,
  output ftp_pkg::out_item_t      push_item_o
);
  import ftp_pkg::*;

  pos_t        pos_q, pos_d;
  logic [15:0] et_q, et_d;
  logic [7:0]  proto_q, proto_d;
  logic [63:0] src_hi_q, src_hi_d, src_lo_q, src_lo_d;
  logic [63:0] dst_hi_q, dst_hi_d, dst_lo_q, dst_lo_d;
  logic [15:0] w0_q, w0_d, w1_q, w1_d;

  logic        hit;
  logic [7:0]  b;
  pos_t        len;
  pos_t        l4base;
  pos_t        need;
  logic [1:0]  l3;
  logic        pass;

  assign in_ready_o = ~q_full_i;
  assign hit        = in_valid_i & in_ready_o;
  assign b          = in_item_i.frame_byte;

  // field capture for the current byte
  always_comb begin
    et_d     = et_q;
    proto_d  = proto_q;
    src_hi_d = src_hi_q;
    src_lo_d = src_lo_q;
    dst_hi_d = dst_hi_q;
    dst_lo_d = dst_lo_q;
    w0_d     = w0_q;
    w1_d     = w1_q;
    if (pos_q == EthTypeHiAt || pos_q == EthTypeLoAt) begin
      et_d = {et_q[7:0], b};
    end
    if (pos_q >= EthHdrLen && et_q == ETH_TYPE_IPV4) begin
      if (pos_q == V4ProtoAt) begin
        proto_d = b;
      end
      if (pos_q >= V4SrcAt && pos_q < V4DstAt) begin
        src_lo_d = {src_lo_q[55:0], b};
      end
      if (pos_q >= V4DstAt && pos_q < V4L4Base) begin
        dst_lo_d = {dst_lo_q[55:0], b};
      end
      if (pos_q == V4L4Base || pos_q == V4L4Base + 7'd1) begin
        w0_d = {w0_q[7:0], b};
      end
      if (pos_q == V4L4Base + 7'd2 || pos_q == V4L4Base + 7'd3) begin
        w1_d = {w1_q[7:0], b};
      end
    end else if (pos_q >= EthHdrLen && et_q == ETH_TYPE_IPV6) begin
      if (pos_q == V6ProtoAt) begin
        proto_d = b;
      end
      if (pos_q >= V6SrcAt && pos_q < V6SrcAt + 7'd8) begin
        src_hi_d = {src_hi_q[55:0], b};
      end
      if (pos_q >= V6SrcAt + 7'd8 && pos_q < V6DstAt) begin
        src_lo_d = {src_lo_q[55:0], b};
      end
      if (pos_q >= V6DstAt && pos_q < V6DstAt + 7'd8) begin
        dst_hi_d = {dst_hi_q[55:0], b};
      end
      if (pos_q >= V6DstAt + 7'd8 && pos_q < V6L4Base) begin
        dst_lo_d = {dst_lo_q[55:0], b};
      end
      if (pos_q == V6L4Base || pos_q == V6L4Base + 7'd1) begin
        w0_d = {w0_q[7:0], b};
      end
      if (pos_q == V6L4Base + 7'd2 || pos_q == V6L4Base + 7'd3) begin
        w1_d = {w1_q[7:0], b};
      end
    end
    pos_d = (pos_q == PosMax) ? pos_q : pos_q + 7'd1;
  end

  // verdict from the fields including the last byte
  always_comb begin
    len    = pos_q + 7'd1;
    l3     = L3_OTHER;
    l4base = '0;
    need   = '0;
    pass   = 1'b0;
    if (len >= EthHdrLen) begin
      if (et_d == ETH_TYPE_IPV4) begin
        l3     = L3_IPV4;
        l4base = V4L4Base;
      end else if (et_d == ETH_TYPE_IPV6) begin
        l3     = L3_IPV6;
        l4base = V6L4Base;
      end
    end
    if (l3 != L3_OTHER && len >= l4base) begin
      if (proto_d == PROTO_ICMP || proto_d == PROTO_UDP) begin
        need = l4base + SmallL4Len;
      end else if (proto_d == PROTO_TCP) begin
        need = l4base + TcpHdrLen;
      end
      pass = (need != '0) && (len >= need);
    end

    push_item_o         = '0;
    push_item_o.l3_kind = l3;
    if (pass) begin
      push_item_o.pass        = 1'b1;
      push_item_o.l4_kind     = proto_d;
      push_item_o.src_addr_hi = src_hi_d;
      push_item_o.src_addr_lo = src_lo_d;
      push_item_o.dst_addr_hi = dst_hi_d;
      push_item_o.dst_addr_lo = dst_lo_d;
      if (proto_d == PROTO_ICMP) begin
        push_item_o.sport = {8'h00, w0_d[15:8]};
        push_item_o.dport = {8'h00, w0_d[7:0]};
      end else begin
        push_item_o.sport = w0_d;
        push_item_o.dport = w1_d;
      end
    end
  end

  assign push_o = hit & in_item_i.last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      et_q     <= '0;
      proto_q  <= '0;
      src_hi_q <= '0;
      src_lo_q <= '0;
      dst_hi_q <= '0;
      dst_lo_q <= '0;
      w0_q     <= '0;
      w1_q     <= '0;
    end else if (hit) begin
      if (in_item_i.last_byte) begin
        // next frame starts from a clean slate
        pos_q    <= '0;
        et_q     <= '0;
        proto_q  <= '0;
        src_hi_q <= '0;
        src_lo_q <= '0;
        dst_hi_q <= '0;
        dst_lo_q <= '0;
        w0_q     <= '0;
        w1_q     <= '0;
      end else begin
        pos_q    <= pos_d;
        et_q     <= et_d;
        proto_q  <= proto_d;
        src_hi_q <= src_hi_d;
        src_lo_q <= src_lo_d;
        dst_hi_q <= dst_hi_d;
        dst_lo_q <= dst_lo_d;
        w0_q     <= w0_d;
        w1_q     <= w1_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ftp_queue.sv
// verdict queue between front and back
`default_nettype none

module ftp_queue #(
  parameter int unsigned Depth = ftp_pkg::QueueDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ftp_pkg::out_item_t push_item_i,
  input  wire logic               pop_i,
  output ftp_pkg::q_status_t      status_o,
  output ftp_pkg::out_item_t      head_o
);
  import ftp_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  out_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == Full);
  assign status_o.valid = (cnt_q != '0);
  assign head_o         = mem_q[rd_q];

  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & status_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ftp_back.sv
// back part: output register that hands verdicts to the receiver
`default_nettype none

module ftp_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire ftp_pkg::out_item_t head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ftp_pkg::out_item_t      out_item_o
);
  import ftp_pkg::*;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  // refill when empty or when the held item leaves this cycle
  assign pop_o = q_valid_i & (~out_valid_q | out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= head_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/core/flow_tuple_header_parser.sv
// Flow tuple header parser: one Ethernet frame byte per input item, one
// verdict item per frame carrying pass/drop, L3/L4 kind, addresses and ports.
//
// Input channel (in_valid_i/in_ready_o/in_item_i): one byte per cycle while
// the queue has room, with last_byte marking the end of the frame. Bytes are
// taken back to back; the front captures fields at fixed offsets and builds
// the verdict in the cycle the last byte is accepted.
// Output channel (out_valid_o/out_ready_i/out_item_o): one verdict per frame,
// valid once it has passed from the queue into the output register.
// Throughput: one byte per cycle while the queue is not full, set by the
// position compare and capture in the front. A queue of QueueDepth verdicts
// plus the output register sits between front and back.
// Stall: while the receiver holds off, verdicts pile up in the queue; once
// it is full, in_ready_o drops and the input stalls until a slot frees.
// Reset: position, captured fields and queue clear; the first byte after
// reset is taken as the destination MAC of a new frame.
`default_nettype none

module flow_tuple_header_parser #(
  parameter int unsigned QueueDepth = ftp_pkg::QueueDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ftp_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ftp_pkg::out_item_t      out_item_o
);
  import ftp_pkg::*;

  q_status_t q_status;
  logic      push, pop;
  out_item_t push_item, head;

  ftp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_status.full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  ftp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .status_o    (q_status),
    .head_o      (head)
  );

  ftp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_status.valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
